// File: sv/bpcg_pkg.sv
// ----------------------------------------------------------------------------
// bpcg_pkg
// shared types and constants of the baseline phasor channel generator
// ----------------------------------------------------------------------------
package bpcg_pkg;

    localparam int MAX_CHANNELS = 64;
    localparam int CNT_W        = 7;
    localparam int CH_W         = 6;
    localparam int PH_W         = 32;
    localparam int N_W          = 31;
    localparam int ACC_W        = 64;
    localparam int DIVIDEND_W   = 57;

    typedef struct packed {
        logic signed [PH_W-1:0] left_re;
        logic signed [PH_W-1:0] left_im;
        logic signed [PH_W-1:0] right_re;
        logic signed [PH_W-1:0] right_im;
        logic signed [PH_W-1:0] left_step_re;
        logic signed [PH_W-1:0] left_step_im;
        logic signed [PH_W-1:0] right_step_re;
        logic signed [PH_W-1:0] right_step_im;
        logic        [N_W-1:0]  n_cosine;
        logic        [CNT_W-1:0] channel_count;
    } in_t;

    typedef struct packed {
        logic signed [PH_W-1:0] out_re;
        logic signed [PH_W-1:0] out_im;
        logic        [CH_W-1:0] channel_index;
        logic                   last;
    } out_t;

    // control for one product term going into the accumulator
    typedef struct packed {
        logic valid;
        logic to_im;
        logic init;
        logic neg;
        logic half;
    } term_t;

endpackage

// File: sv/bpcg_mac.sv
// ----------------------------------------------------------------------------
// bpcg_mac
// shared 32x32 signed multiplier with a registered product and two 64 bit
// accumulators for the real and imaginary sums
// ----------------------------------------------------------------------------
module bpcg_mac
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  bpcg_pkg::term_t                        term,
    input  logic signed [bpcg_pkg::PH_W-1:0]       op_a,
    input  logic signed [bpcg_pkg::PH_W-1:0]       op_b,
    output logic signed [bpcg_pkg::ACC_W-1:0]      acc_re,
    output logic signed [bpcg_pkg::ACC_W-1:0]      acc_im
);
    import bpcg_pkg::*;

    term_t                    tag_reg;
    logic signed [ACC_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]  acc_re_reg;
    logic signed [ACC_W-1:0]  acc_im_reg;
    logic signed [ACC_W-1:0]  term_val;
    logic signed [ACC_W-1:0]  prod_neg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= term;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ACC_W'(op_a * op_b);
    end

    // halving is a floor shift, taken after the optional negation
    always_comb
    begin
        prod_neg = -prod_reg;
        if (tag_reg.half)
        begin
            term_val = tag_reg.neg ? (prod_neg >>> 1) : (prod_reg >>> 1);
        end
        else
        begin
            term_val = tag_reg.neg ? prod_neg : prod_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_reg.valid)
        begin
            if (tag_reg.to_im)
            begin
                acc_im_reg <= tag_reg.init ? term_val : acc_im_reg + term_val;
            end
            else
            begin
                acc_re_reg <= tag_reg.init ? term_val : acc_re_reg + term_val;
            end
        end
    end

    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;

endmodule

// File: sv/bpcg_div.sv
// ----------------------------------------------------------------------------
// bpcg_div
// restoring divider, one quotient bit a cycle; flags a quotient of 2^32 or
// more and otherwise gives the 32 bit quotient
// ----------------------------------------------------------------------------
module bpcg_div
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [bpcg_pkg::DIVIDEND_W-1:0]      dividend,
    input  logic [bpcg_pkg::N_W-1:0]             divisor,
    output logic                                 done,
    output logic                                 ovf,
    output logic [bpcg_pkg::PH_W-1:0]            quo
);
    import bpcg_pkg::*;

    localparam int STEPS = PH_W;

    logic              busy_reg;
    logic              done_reg;
    logic [5:0]        cnt_reg;
    logic [PH_W-1:0]   rem_reg;
    logic [PH_W-1:0]   lo_reg;
    logic [PH_W-1:0]   quo_reg;
    logic              ovf_reg;
    logic [PH_W-1:0]   trial;
    logic [PH_W-1:0]   div_ext;
    logic              ge;

    assign div_ext = {1'b0, divisor};
    assign trial   = {rem_reg[PH_W-2:0], lo_reg[PH_W-1]};
    assign ge      = (trial >= div_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(STEPS))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // first busy cycle only checks the upper part against the divisor
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {{(2*PH_W-DIVIDEND_W){1'b0}}, dividend[DIVIDEND_W-1:PH_W]};
            lo_reg  <= dividend[PH_W-1:0];
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0)
            begin
                ovf_reg <= (rem_reg >= div_ext);
            end
            else
            begin
                rem_reg <= ge ? (trial - div_ext) : trial;
                lo_reg  <= {lo_reg[PH_W-2:0], 1'b0};
                quo_reg <= {quo_reg[PH_W-2:0], ge};
            end
        end
    end

    assign done = done_reg;
    assign ovf  = ovf_reg;
    assign quo  = quo_reg;

endmodule

// File: sv/baseline_phasor_channel_generator_unit.sv
// ----------------------------------------------------------------------------
// baseline_phasor_channel_generator_unit
// one visibility per frequency channel from two station phasors and steps
// ----------------------------------------------------------------------------
// Takes one item at a time and produces channel_count results (clamped to 1 to
// 64; a count of 0 gives one result). Channel 0 is formed from a four-term
// complex product on the shared multiplier, then two divisions by n (real,
// then imaginary) on the bit-serial divider (load, overflow check, 32 quotient
// bits, done), then the step phasor product and its rounding (skipped for a
// single channel) and the load of the output register. Each further channel
// needs one complex product on the shared multiplier, a rounding step and an
// output step. A result that is still waiting in the output register holds
// the sequencer until it is taken. req_ready is high only between items; the
// last result may still wait in the output register while the next item is
// taken.
module baseline_phasor_channel_generator_unit
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  bpcg_pkg::in_t   req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output bpcg_pkg::out_t  rsp
);
    import bpcg_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DLOAD = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SRND  = 3'd4;
    localparam logic [2:0] S_CRND  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam logic [1:0] OP_STN = 2'd0;
    localparam logic [1:0] OP_STP = 2'd1;
    localparam logic [1:0] OP_CHN = 2'd2;

    localparam logic [2:0] TERMS = 3'd4;

    localparam logic signed [PH_W-1:0] SAT_MAX = {1'b0, {(PH_W-1){1'b1}}};
    localparam logic signed [PH_W-1:0] SAT_MIN = {1'b1, {(PH_W-1){1'b0}}};

    logic [2:0]              state_reg, state_next;
    logic [2:0]              mstep_reg, mstep_next;
    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              op_reg, op_next;
    logic                    comp_reg, comp_next;
    logic                    sign_reg, sign_next;
    in_t                     in_reg, in_next;
    logic [N_W-1:0]          n_reg, n_next;
    logic [CH_W-1:0]         k_reg, k_next;
    logic [CH_W-1:0]         kmax_reg, kmax_next;
    logic signed [PH_W-1:0]  v_re_reg, v_re_next;
    logic signed [PH_W-1:0]  v_im_reg, v_im_next;
    logic signed [PH_W-1:0]  d_re_reg, d_re_next;
    logic signed [PH_W-1:0]  d_im_reg, d_im_next;
    out_t                    out_reg, out_next;

    term_t                   term;
    logic signed [PH_W-1:0]  op_a, op_b;
    logic signed [ACC_W-1:0] acc_re, acc_im;
    logic                    div_start;
    logic [DIVIDEND_W-1:0]   dividend;
    logic                    div_done, div_ovf;
    logic [PH_W-1:0]         div_quo;
    logic signed [PH_W-1:0]  div_res;
    logic signed [ACC_W-1:0] div_sel;
    logic [ACC_W-1:0]        div_mag;
    logic [ACC_W-1:0]        div_sum;
    logic                    out_free;

    // rounding of a product sum to nearest, ties away from zero, with saturation
    function automatic logic signed [PH_W-1:0] round_chan(input logic signed [ACC_W-1:0] x);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] sum;
        logic [36:0]      q;
        logic             big;
        begin
            mag = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
            sum = mag + (ACC_W'(1) << 26);
            q   = sum[63:27];
            if (x[ACC_W-1])
            begin
                big = (|q[36:32]) || (q[31] && (|q[30:0]));
                round_chan = big ? SAT_MIN : PH_W'(-q[31:0]);
            end
            else
            begin
                big = |q[36:31];
                round_chan = big ? SAT_MAX : PH_W'(q[31:0]);
            end
        end
    endfunction

    // step phasor to Q5.27; magnitude never exceeds 2^30 so no saturation
    function automatic logic signed [PH_W-1:0] round_step(input logic signed [ACC_W-1:0] x);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] sum;
        logic [PH_W-1:0]  q;
        begin
            mag = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
            sum = mag + (ACC_W'(1) << 31);
            q   = sum[63:32];
            round_step = x[ACC_W-1] ? PH_W'(-q) : PH_W'(q);
        end
    endfunction

    bpcg_mac u_mac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .term   (term),
        .op_a   (op_a),
        .op_b   (op_b),
        .acc_re (acc_re),
        .acc_im (acc_im)
    );

    bpcg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (n_reg),
        .done     (div_done),
        .ovf      (div_ovf),
        .quo      (div_quo)
    );

    // term sequencing: conjugate product for the phasors, plain for channels
    always_comb
    begin
        logic               conj;
        logic signed [PH_W-1:0] ar, ai, br, bi;
        conj = (op_reg != OP_CHN);
        case (op_reg)
            OP_STN:
            begin
                ar = in_reg.right_re;  ai = in_reg.right_im;
                br = in_reg.left_re;   bi = in_reg.left_im;
            end
            OP_STP:
            begin
                ar = in_reg.right_step_re;  ai = in_reg.right_step_im;
                br = in_reg.left_step_re;   bi = in_reg.left_step_im;
            end
            default:
            begin
                ar = v_re_reg;  ai = v_im_reg;
                br = d_re_reg;  bi = d_im_reg;
            end
        endcase
        term.valid = (state_reg == S_MUL) && (mstep_reg < TERMS);
        term.half  = conj;
        case (mstep_reg[1:0])
            2'd0:
            begin
                op_a = ar;  op_b = br;
                term.to_im = 1'b0;  term.init = 1'b1;  term.neg = 1'b0;
            end
            2'd1:
            begin
                op_a = ai;  op_b = bi;
                term.to_im = 1'b0;  term.init = 1'b0;  term.neg = !conj;
            end
            2'd2:
            begin
                op_a = conj ? ai : ar;  op_b = conj ? br : bi;
                term.to_im = 1'b1;  term.init = 1'b1;  term.neg = 1'b0;
            end
            default:
            begin
                op_a = conj ? ar : ai;  op_b = conj ? bi : br;
                term.to_im = 1'b1;  term.init = 1'b0;  term.neg = conj;
            end
        endcase
    end

    // dividend is (|S| + 32n) >> 6, so the divide by 64n rounds to nearest
    assign div_sel   = comp_reg ? acc_im : acc_re;
    assign div_mag   = div_sel[ACC_W-1] ? ACC_W'(-div_sel) : ACC_W'(div_sel);
    assign div_sum   = div_mag + {{(ACC_W-N_W-5){1'b0}}, n_reg, 5'b0};
    assign dividend  = div_sum[DIVIDEND_W+5:6];
    assign div_start = (state_reg == S_DLOAD);

    always_comb
    begin
        if (sign_reg)
        begin
            div_res = (div_ovf || (div_quo[PH_W-1] && (|div_quo[PH_W-2:0])))
                      ? SAT_MIN : PH_W'(-div_quo);
        end
        else
        begin
            div_res = (div_ovf || div_quo[PH_W-1]) ? SAT_MAX : PH_W'(div_quo);
        end
    end

    assign out_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        mstep_next     = mstep_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        comp_next      = comp_reg;
        sign_next      = sign_reg;
        in_next        = in_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        kmax_next      = kmax_reg;
        v_re_next      = v_re_reg;
        v_im_next      = v_im_reg;
        d_re_next      = d_re_reg;
        d_im_next      = d_im_reg;
        out_next       = out_reg;

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    in_next    = req;
                    n_next     = (req.n_cosine == '0) ? N_W'(1) : req.n_cosine;
                    if (req.channel_count == '0)
                    begin
                        kmax_next = '0;
                    end
                    else if (req.channel_count > CNT_W'(MAX_CHANNELS))
                    begin
                        kmax_next = CH_W'(MAX_CHANNELS - 1);
                    end
                    else
                    begin
                        kmax_next = CH_W'(req.channel_count - CNT_W'(1));
                    end
                    k_next     = '0;
                    op_next    = OP_STN;
                    mstep_next = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                mstep_next = mstep_reg + 3'd1;
                if (mstep_reg == TERMS)
                begin
                    mstep_next = '0;
                    case (op_reg)
                        OP_STN:
                        begin
                            comp_next  = 1'b0;
                            state_next = S_DLOAD;
                        end
                        OP_STP:  state_next = S_SRND;
                        default: state_next = S_CRND;
                    endcase
                end
            end
            S_DLOAD:
            begin
                sign_next  = div_sel[ACC_W-1];
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (!comp_reg)
                    begin
                        v_re_next  = div_res;
                        comp_next  = 1'b1;
                        state_next = S_DLOAD;
                    end
                    else
                    begin
                        v_im_next = div_res;
                        if (kmax_reg != '0)
                        begin
                            op_next    = OP_STP;
                            state_next = S_MUL;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                end
            end
            S_SRND:
            begin
                d_re_next  = round_step(acc_re);
                d_im_next  = round_step(acc_im);
                state_next = S_OUT;
            end
            S_CRND:
            begin
                v_re_next  = round_chan(acc_re);
                v_im_next  = round_chan(acc_im);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.out_re        = v_re_reg;
                    out_next.out_im        = v_im_reg;
                    out_next.channel_index = k_reg;
                    out_next.last          = (k_reg == kmax_reg);
                    if (k_reg == kmax_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + CH_W'(1);
                        op_next    = OP_CHN;
                        state_next = S_MUL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mstep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mstep_reg     <= mstep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        comp_reg <= comp_next;
        sign_reg <= sign_next;
        in_reg   <= in_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        kmax_reg <= kmax_next;
        v_re_reg <= v_re_next;
        v_im_reg <= v_im_next;
        d_re_reg <= d_re_next;
        d_im_reg <= d_im_next;
        out_reg  <= out_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule
